>>> rtl/lcdseq_pkg.sv
// Package with shared types, constants and the step table for the LCD bus write sequencer.
package lcdseq_pkg;

  localparam int unsigned WAIT_W = 16;
  localparam int unsigned STEP_W = 4;

  localparam logic [2:0] OP_WRITE  = 3'd0;
  localparam logic [2:0] OP_INIT   = 3'd1;
  localparam logic [2:0] OP_SELECT = 3'd2;
  localparam logic [2:0] OP_ECHO   = 3'd3;
  localparam logic [2:0] OP_CURSOR = 3'd4;

  localparam logic [1:0] REG_FOUR_BIT  = 2'd0;
  localparam logic [1:0] REG_FUNC_WORD = 2'd1;
  localparam logic [1:0] REG_MODE_WORD = 2'd2;
  localparam logic [1:0] REG_DISP_WORD = 2'd3;

  localparam logic [3:0] ENABLE_FIRST  = 4'b0100;
  localparam logic [3:0] ENABLE_SECOND = 4'b1000;
  localparam logic [3:0] ENABLE_BOTH   = 4'b1100;

  localparam logic [7:0] CURSOR_LINE0 = 8'h80;
  localparam logic [7:0] CURSOR_LINE1 = 8'hC0;
  localparam logic [5:0] CURSOR_COLS  = 6'd40;
  localparam logic [7:0] BYTE_WAKE    = 8'h30;
  localparam logic [7:0] BYTE_4BIT    = 8'h20;
  localparam logic [7:0] BYTE_CLEAR   = 8'h01;
  localparam logic [7:0] BYTE_HOME    = 8'h02;

  localparam logic [WAIT_W-1:0] WAIT_POWER_ON = 16'd55000;
  localparam logic [WAIT_W-1:0] WAIT_SYNC0    = 16'd4100;
  localparam logic [WAIT_W-1:0] WAIT_SYNC     = 16'd100;
  localparam logic [WAIT_W-1:0] WAIT_CMD      = 16'd40;
  localparam logic [WAIT_W-1:0] WAIT_DATA     = 16'd2;
  localparam logic [WAIT_W-1:0] WAIT_SLOW_CMD = 16'd1640;
  localparam logic [WAIT_W-1:0] WAIT_PULSE    = 16'd1;
  localparam logic [WAIT_W-1:0] WAIT_NONE     = 16'd0;

  localparam logic [1:0] PH_LOW0 = 2'd0;
  localparam logic [1:0] PH_HIGH = 2'd1;
  localparam logic [1:0] PH_LOW1 = 2'd2;

  localparam logic [STEP_W-1:0] STEP_SYNC0    = 4'd0;
  localparam logic [STEP_W-1:0] STEP_SYNC1    = 4'd1;
  localparam logic [STEP_W-1:0] STEP_SYNC2    = 4'd2;
  localparam logic [STEP_W-1:0] STEP_4BIT     = 4'd3;
  localparam logic [STEP_W-1:0] STEP_FUNCTION = 4'd4;
  localparam logic [STEP_W-1:0] STEP_CLEAR    = 4'd5;
  localparam logic [STEP_W-1:0] STEP_HOME     = 4'd6;
  localparam logic [STEP_W-1:0] STEP_ENTRY    = 4'd7;
  localparam logic [STEP_W-1:0] STEP_DISPLAY  = 4'd8;
  localparam logic [STEP_W-1:0] STEP_USER     = 4'd9;

  typedef struct packed {
    logic       four_bit;
    logic [7:0] func_word;
    logic [7:0] mode_word;
    logic [7:0] disp_word;
  } cfg_t;

  typedef struct packed {
    logic [7:0]        data;
    logic              rs;
    logic              nibbles;
    logic [WAIT_W-1:0] after;
  } step_info_t;

  typedef struct packed {
    logic              load;
    logic              from_zero;
    logic [WAIT_W-1:0] add;
  } wait_op_t;

  function automatic step_info_t step_info(input logic [STEP_W-1:0] step, input cfg_t cfg,
                                           input logic [7:0] user_data, input logic user_rs);
    step_info_t s;
    s.data    = '0;
    s.rs      = 1'b0;
    s.nibbles = cfg.four_bit;
    s.after   = WAIT_CMD;
    case (step)
      STEP_SYNC0: begin
        s.data = BYTE_WAKE; s.nibbles = 1'b0; s.after = WAIT_SYNC0;
      end
      STEP_SYNC1, STEP_SYNC2: begin
        s.data = BYTE_WAKE; s.nibbles = 1'b0; s.after = WAIT_SYNC;
      end
      STEP_4BIT: begin
        s.data = BYTE_4BIT; s.nibbles = 1'b0; s.after = WAIT_NONE;
      end
      STEP_FUNCTION: s.data = cfg.func_word;
      STEP_CLEAR: begin
        s.data = BYTE_CLEAR; s.after = WAIT_SLOW_CMD;
      end
      STEP_HOME: begin
        s.data = BYTE_HOME; s.after = WAIT_SLOW_CMD;
      end
      STEP_ENTRY: s.data = cfg.mode_word;
      STEP_DISPLAY: s.data = cfg.disp_word;
      STEP_USER: begin
        s.data  = user_data;
        s.rs    = user_rs;
        s.after = user_rs ? WAIT_DATA : WAIT_CMD;
      end
      default: s.data = '0;
    endcase
    return s;
  endfunction

endpackage

>>> rtl/lcdseq_if.sv
// Handshake interfaces for the command input and the bus write output.
interface lcdseq_cmd_if;
  logic       valid;
  logic       ready;
  logic [2:0] opcode;
  logic [7:0] data_byte;
  logic       register_select;
  logic [1:0] select_index;
  logic [1:0] cursor_line;
  logic [5:0] cursor_col;

  modport source(output valid, opcode, data_byte, register_select, select_index,
                 cursor_line, cursor_col, input ready);
  modport sink(input valid, opcode, data_byte, register_select, select_index,
               cursor_line, cursor_col, output ready);
endinterface

interface lcdseq_bus_if;
  logic        valid;
  logic        ready;
  logic [3:0]  bus_control;
  logic [7:0]  bus_data;
  logic [15:0] wait_before_us;
  logic        last;

  modport source(output valid, bus_control, bus_data, wait_before_us, last, input ready);
  modport sink(input valid, bus_control, bus_data, wait_before_us, last, output ready);
endinterface

>>> rtl/char_lcd_bus_write_sequencer_top.sv
// Top level of the character LCD bus write sequencer.
// Each accepted command is decoded in the idle state; commands that emit bus words then put out
// one word per cycle from an output register, slowed only by backpressure on the bus side,
// and take no new command until the final word has been loaded. A byte write or cursor
// command emits 3 words in 8-bit mode or 6 in 4-bit mode; init first adds the power-on wait
// through the single saturating wait adder, then emits 24 (8-bit) or 42 (4-bit) words;
// select and echo emit no words. Waits that follow a word ride on the next word, even one
// from a later command, and saturate at 65535 us.
module char_lcd_bus_write_sequencer_top (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [7:0]          cfg_data,
  lcdseq_cmd_if.sink          cmd,
  lcdseq_bus_if.source        bus
);

  lcdseq_pkg::cfg_t                  cfg;
  lcdseq_pkg::wait_op_t              wait_op;
  logic [lcdseq_pkg::WAIT_W-1:0]     pending;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.four_bit  <= 1'b1;
      cfg.func_word <= 8'd40;
      cfg.mode_word <= 8'd6;
      cfg.disp_word <= 8'd12;
    end else if (cfg_we) begin
      unique case (cfg_index)
        lcdseq_pkg::REG_FOUR_BIT:  cfg.four_bit  <= cfg_data[0];
        lcdseq_pkg::REG_FUNC_WORD: cfg.func_word <= cfg_data;
        lcdseq_pkg::REG_MODE_WORD: cfg.mode_word <= cfg_data;
        lcdseq_pkg::REG_DISP_WORD: cfg.disp_word <= cfg_data;
        default: cfg.four_bit <= cfg.four_bit;
      endcase
    end
  end

  lcdseq_wait u_wait (
    .clk     (clk),
    .rst     (rst),
    .op      (wait_op),
    .pending (pending)
  );

  lcdseq_seq u_seq (
    .clk             (clk),
    .rst             (rst),
    .cfg             (cfg),
    .cmd_valid       (cmd.valid),
    .cmd_ready       (cmd.ready),
    .opcode          (cmd.opcode),
    .data_byte       (cmd.data_byte),
    .register_select (cmd.register_select),
    .select_index    (cmd.select_index),
    .cursor_line     (cmd.cursor_line),
    .cursor_col      (cmd.cursor_col),
    .pending         (pending),
    .wait_op         (wait_op),
    .out_valid       (bus.valid),
    .out_ready       (bus.ready),
    .bus_control     (bus.bus_control),
    .bus_data        (bus.bus_data),
    .wait_before_us  (bus.wait_before_us),
    .last            (bus.last)
  );

  a_strobe_no_wait: assert property (@(posedge clk) disable iff (rst)
    bus.valid && (bus.bus_control[3:2] != 2'b00) |-> bus.wait_before_us == '0)
    else $error("enable strobe word carries a wait");

  a_busy_mid_command: assert property (@(posedge clk) disable iff (rst)
    bus.valid && !bus.last |-> !cmd.ready)
    else $error("command taken before the previous command finished");

  a_nibble_low_clear: assert property (@(posedge clk) disable iff (rst)
    bus.valid && cfg.four_bit |-> bus.bus_data[3:0] == 4'h0)
    else $error("4-bit mode word drives low data lines");

endmodule

>>> rtl/lcdseq_wait.sv
// Shared saturating adder and pending wait register.
module lcdseq_wait (
  input  logic                             clk,
  input  logic                             rst,
  input  lcdseq_pkg::wait_op_t             op,
  output logic [lcdseq_pkg::WAIT_W-1:0]    pending
);

  logic [lcdseq_pkg::WAIT_W:0]   sum;
  logic [lcdseq_pkg::WAIT_W-1:0] pending_next;

  assign sum = {1'b0, (op.from_zero ? {lcdseq_pkg::WAIT_W{1'b0}} : pending)} + {1'b0, op.add};
  assign pending_next = sum[lcdseq_pkg::WAIT_W] ? '1 : sum[lcdseq_pkg::WAIT_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else if (op.load) begin
      pending <= pending_next;
    end
  end

endmodule

>>> rtl/lcdseq_seq.sv
// Command decoder and write sequencer with step, nibble and phase counters.
module lcdseq_seq (
  input  logic                             clk,
  input  logic                             rst,
  input  lcdseq_pkg::cfg_t                 cfg,
  input  logic                             cmd_valid,
  output logic                             cmd_ready,
  input  logic [2:0]                       opcode,
  input  logic [7:0]                       data_byte,
  input  logic                             register_select,
  input  logic [1:0]                       select_index,
  input  logic [1:0]                       cursor_line,
  input  logic [5:0]                       cursor_col,
  input  logic [lcdseq_pkg::WAIT_W-1:0]    pending,
  output lcdseq_pkg::wait_op_t             wait_op,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [3:0]                       bus_control,
  output logic [7:0]                       bus_data,
  output logic [lcdseq_pkg::WAIT_W-1:0]    wait_before_us,
  output logic                             last
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_PRE  = 3'b010,
    S_RUN  = 3'b100
  } state_t;

  state_t                          state;
  logic [lcdseq_pkg::STEP_W-1:0]   step;
  logic                            nibble;
  logic [1:0]                      phase;
  logic [7:0]                      byte_data;
  logic                            byte_rs;
  logic [3:0]                      enable_bits;

  lcdseq_pkg::step_info_t          info;
  logic                            emit;
  logic                            step_end;
  logic                            cmd_done;
  logic [7:0]                      write_data;
  logic [3:0]                      write_ctrl;
  logic [lcdseq_pkg::WAIT_W-1:0]   write_add;
  logic [7:0]                      cursor_byte;
  logic                            cursor_ok;

  assign info = lcdseq_pkg::step_info(step, cfg, byte_data, byte_rs);
  assign cmd_ready = (state == S_IDLE);
  assign emit = (state == S_RUN) && (!out_valid || out_ready);
  assign step_end = (phase == lcdseq_pkg::PH_LOW1) && (!info.nibbles || nibble);
  assign cmd_done = step_end &&
                    ((step == lcdseq_pkg::STEP_USER) || (step == lcdseq_pkg::STEP_DISPLAY));

  assign cursor_ok = !cursor_line[1] && (cursor_col < lcdseq_pkg::CURSOR_COLS);
  assign cursor_byte = (cursor_line[0] ? lcdseq_pkg::CURSOR_LINE1 : lcdseq_pkg::CURSOR_LINE0)
                       + {2'b00, cursor_col};

  always_comb begin
    if (!info.nibbles) begin
      write_data = info.data;
    end else if (nibble) begin
      write_data = {info.data[3:0], 4'h0};
    end else begin
      write_data = {info.data[7:4], 4'h0};
    end
    write_ctrl = {3'b000, info.rs};
    if (phase == lcdseq_pkg::PH_HIGH) begin
      write_ctrl = write_ctrl | enable_bits;
    end
    case (phase)
      lcdseq_pkg::PH_LOW0: write_add = lcdseq_pkg::WAIT_NONE;
      lcdseq_pkg::PH_HIGH: write_add = lcdseq_pkg::WAIT_PULSE;
      default: write_add = step_end ? info.after : lcdseq_pkg::WAIT_PULSE;
    endcase
  end

  always_comb begin
    wait_op = '0;
    if (state == S_PRE) begin
      wait_op.load      = 1'b1;
      wait_op.from_zero = 1'b0;
      wait_op.add       = lcdseq_pkg::WAIT_POWER_ON;
    end else if (emit) begin
      wait_op.load      = 1'b1;
      wait_op.from_zero = 1'b1;
      wait_op.add       = write_add;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      step        <= lcdseq_pkg::STEP_SYNC0;
      nibble      <= 1'b0;
      phase       <= lcdseq_pkg::PH_LOW0;
      enable_bits <= lcdseq_pkg::ENABLE_FIRST;
      out_valid   <= 1'b0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            nibble <= 1'b0;
            phase  <= lcdseq_pkg::PH_LOW0;
            case (opcode)
              lcdseq_pkg::OP_WRITE: begin
                byte_data <= data_byte;
                byte_rs   <= register_select;
                step      <= lcdseq_pkg::STEP_USER;
                state     <= S_RUN;
              end
              lcdseq_pkg::OP_INIT: begin
                step  <= lcdseq_pkg::STEP_SYNC0;
                state <= S_PRE;
              end
              lcdseq_pkg::OP_SELECT: begin
                if (!select_index[1]) begin
                  enable_bits <= select_index[0] ? lcdseq_pkg::ENABLE_SECOND
                                                 : lcdseq_pkg::ENABLE_FIRST;
                end
              end
              lcdseq_pkg::OP_ECHO: enable_bits <= lcdseq_pkg::ENABLE_BOTH;
              lcdseq_pkg::OP_CURSOR: begin
                if (cursor_ok) begin
                  byte_data <= cursor_byte;
                  byte_rs   <= 1'b0;
                  step      <= lcdseq_pkg::STEP_USER;
                  state     <= S_RUN;
                end
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        S_PRE: state <= S_RUN;
        S_RUN: begin
          if (emit) begin
            if (phase != lcdseq_pkg::PH_LOW1) begin
              phase <= phase + 2'd1;
            end else if (info.nibbles && !nibble) begin
              nibble <= 1'b1;
              phase  <= lcdseq_pkg::PH_LOW0;
            end else begin
              nibble <= 1'b0;
              phase  <= lcdseq_pkg::PH_LOW0;
              if (cmd_done) begin
                state <= S_IDLE;
                if (step != lcdseq_pkg::STEP_USER) begin
                  enable_bits <= lcdseq_pkg::ENABLE_FIRST;
                end
              end else if ((step == lcdseq_pkg::STEP_SYNC2) && !cfg.four_bit) begin
                step <= lcdseq_pkg::STEP_FUNCTION;
              end else begin
                step <= step + 4'd1;
              end
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      bus_control    <= write_ctrl;
      bus_data       <= write_data;
      wait_before_us <= pending;
      last           <= cmd_done;
    end
  end

endmodule
